// ----- design/mlpf_pkg.sv -----
// ----------------------------------------------------------------------------
// mlpf_pkg: shared types and helpers for the motor link packet framer
// Item formats, reply and payload codes, and the CRC-16 byte step
// (polynomial 0x1021, MSB first).
// ----------------------------------------------------------------------------
package mlpf_pkg;

  // stream widths, whole bytes
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 88;

  // crc and reply constants
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [7:0]  AckByte = 8'hFF;

  // bytes kept behind the current reply byte (longest reply less one)
  localparam int unsigned ShiftBytes = 9;

  // outgoing payload layout
  typedef enum logic [1:0] {
    PL_READ = 2'd0,
    PL_W16  = 2'd1,
    PL_W32  = 2'd2
  } pl_kind_e;

  // expected reply layout
  typedef enum logic [1:0] {
    RK_ACK  = 2'd0,
    RK_W16  = 2'd1,
    RK_W32S = 2'd2,
    RK_W64  = 2'd3
  } reply_kind_e;

  // reply outcome
  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_CRC = 2'd1,
    ST_ACK = 2'd2,
    ST_LEN = 2'd3
  } status_e;

  // classified item held in the queue
  typedef struct packed {
    logic               is_reply;
    logic [7:0]         address;
    logic [7:0]         command;
    pl_kind_e           pl_kind;
    logic [3:0]         last_idx;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    reply_kind_e        reply_kind;
    logic [7:0]         rx_byte;
    logic               rx_last;
  } entry_t;

  // one result item
  typedef struct packed {
    logic               tx_valid;
    logic [7:0]         tx_byte;
    logic               tx_last;
    logic               reply_valid;
    status_e            status;
    logic signed [31:0] word_a;
    logic signed [31:0] word_b;
    logic [7:0]         status_byte;
  } res_t;

  // crc-16 over one byte, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // reply length in bytes for each kind
  function automatic logic [3:0] reply_len(input reply_kind_e k);
    logic [3:0] len;
    unique case (k)
      RK_ACK:  len = 4'd1;
      RK_W16:  len = 4'd4;
      RK_W32S: len = 4'd7;
      RK_W64:  len = 4'd10;
      default: len = 4'd1;
    endcase
    return len;
  endfunction

endpackage

// ----- design/motor_link_packet_framer_top.sv -----
// ----------------------------------------------------------------------------
// motor_link_packet_framer_top: command framer and reply checker
// Builds CRC-16 protected command frames for a packet-serial motor
// controller and checks the reply bytes against the expected reply kind.
// ----------------------------------------------------------------------------
// usage
//   input stream: tuser low sends a command frame, tuser high carries one
//   received reply byte, tlast marks the last reply byte delivered
//   output stream: tuser[0] flags a frame byte (tlast on the final one),
//   tuser[1] flags a finished reply with its status and decoded words
//   throughput: a send item gives 2, 8 or 12 frame bytes, one per cycle
//   while the receiver is ready, set by the byte counter of the back-end
//   sequencer; the next item follows back to back through a two-entry queue
//   path: an input item goes through the queue, then the output register
//   reset: queue and output empty, crc cleared, no reply awaited
//   receiver stall: the output register holds its item, the sequencer
//   waits, and the queue keeps taking input until both entries are full
// ----------------------------------------------------------------------------
module motor_link_packet_framer_top #(
  parameter int unsigned MAX_REPLY_BYTES = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // address, command, payload_kind, value_a, value_b, reply_kind, rx_byte
  input  logic [mlpf_pkg::InDataW-1:0]  s_axis_tdata,
  // action
  input  logic                          s_axis_tuser,
  // rx_last
  input  logic                          s_axis_tlast,
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tx_byte, reply_status, reply_word_a, reply_word_b, reply_status_byte
  output logic [mlpf_pkg::OutDataW-1:0] m_axis_tdata,
  // tx_valid, reply_valid
  output logic [1:0]                    m_axis_tuser,
  // tx_last
  output logic                          m_axis_tlast
);

  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             pop;
  mlpf_pkg::entry_t entry;
  mlpf_pkg::entry_t head;
  mlpf_pkg::res_t   res;

  // input classification
  mlpf_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .push_o        (push),
    .entry_o       (entry)
  );

  // decoupling queue
  mlpf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  // frame sequencer and reply checker
  mlpf_back #(
    .MAX_REPLY_BYTES (MAX_REPLY_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // output packing
  assign m_axis_tdata = {6'b000000, res.status_byte, res.word_b, res.word_a,
                         res.status, res.tx_byte};
  assign m_axis_tuser = {res.reply_valid, res.tx_valid};
  assign m_axis_tlast = res.tx_last;

endmodule

// ----- design/mlpf_front.sv -----
// ----------------------------------------------------------------------------
// mlpf_front: input side of the framer
// Takes items from the input stream, decodes the payload layout and the
// frame length, and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module mlpf_front (
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [mlpf_pkg::InDataW-1:0] s_axis_tdata,
  input  logic                         s_axis_tuser,
  input  logic                         s_axis_tlast,
  input  logic                         q_full_i,
  output logic                         push_o,
  output mlpf_pkg::entry_t             entry_o
);

  logic [1:0] pl_raw;

  // handshake follows queue space only
  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;

  assign pl_raw = s_axis_tdata[17:16];

  // unpack and classify
  always_comb begin
    entry_o            = '0;
    entry_o.is_reply   = s_axis_tuser;
    entry_o.address    = s_axis_tdata[7:0];
    entry_o.command    = s_axis_tdata[15:8];
    entry_o.value_a    = s_axis_tdata[49:18];
    entry_o.value_b    = s_axis_tdata[81:50];
    entry_o.reply_kind = mlpf_pkg::reply_kind_e'(s_axis_tdata[83:82]);
    entry_o.rx_byte    = s_axis_tdata[91:84];
    entry_o.rx_last    = s_axis_tlast;
    // unknown payload code falls back to a read frame
    unique case (pl_raw)
      2'd1: begin
        entry_o.pl_kind  = mlpf_pkg::PL_W16;
        entry_o.last_idx = 4'd7;
      end
      2'd2: begin
        entry_o.pl_kind  = mlpf_pkg::PL_W32;
        entry_o.last_idx = 4'd11;
      end
      default: begin
        entry_o.pl_kind  = mlpf_pkg::PL_READ;
        entry_o.last_idx = 4'd1;
      end
    endcase
  end

endmodule

// ----- design/mlpf_queue.sv -----
// ----------------------------------------------------------------------------
// mlpf_queue: two-entry queue between front and back
// Lets the input side take items while the back end is busy sending a frame.
// ----------------------------------------------------------------------------
module mlpf_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mlpf_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output mlpf_pkg::entry_t head_o
);

  mlpf_pkg::entry_t mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  // pointer and fill update
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- design/mlpf_back.sv -----
// ----------------------------------------------------------------------------
// mlpf_back: frame sequencer and reply checker
// Sends one frame byte per cycle from the queue head while the output is free,
// keeps the running CRC, checks reply bytes and drives the registered output item.
// ----------------------------------------------------------------------------
module mlpf_back #(
  parameter int unsigned MAX_REPLY_BYTES = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  mlpf_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output mlpf_pkg::res_t   res_o
);

  localparam logic [4:0] MaxBytes = 5'(MAX_REPLY_BYTES);

  logic [15:0]          crc_q, crc_d;
  mlpf_pkg::reply_kind_e exp_q, exp_d;
  logic [3:0]           cnt_q, cnt_d;
  logic                 await_q, await_d;
  logic [3:0]           idx_q, idx_d;
  logic [7:0]           sh_q [mlpf_pkg::ShiftBytes];
  logic [7:0]           sh_d [mlpf_pkg::ShiftBytes];
  logic                 out_valid_q, out_valid_d;
  mlpf_pkg::res_t       res_q, res_d;

  logic        out_free;
  logic        load;
  logic [63:0] pw;
  logic [2:0]  pidx;
  logic [2:0]  prev;
  logic        crc_sel;
  logic [7:0]  tx_b;
  logic [15:0] crc_base;
  logic [3:0]  len;
  logic [3:0]  cnt_inc;
  logic [15:0] got;

  assign out_free = !out_valid_q || res_ready_i;

  // payload word, first byte in the top bits
  always_comb begin
    if (head_i.pl_kind == mlpf_pkg::PL_W16) begin
      pw = {head_i.value_a[15:0], head_i.value_b[15:0], 32'h0};
    end else begin
      pw = {head_i.value_a, head_i.value_b};
    end
  end

  // frame byte selection
  assign pidx     = idx_q[2:0] - 3'd2;
  assign prev     = 3'd7 - pidx;
  assign crc_sel  = (head_i.pl_kind != mlpf_pkg::PL_READ) &&
                    (idx_q >= (head_i.last_idx - 4'd1));
  assign crc_base = (idx_q == 4'd0) ? 16'h0000 : crc_q;

  always_comb begin
    if (idx_q == 4'd0) begin
      tx_b = head_i.address;
    end else if (idx_q == 4'd1) begin
      tx_b = head_i.command;
    end else if (crc_sel) begin
      tx_b = (idx_q == head_i.last_idx) ? crc_q[7:0] : crc_q[15:8];
    end else begin
      tx_b = pw[{prev, 3'b000} +: 8];
    end
  end

  // reply length and received crc
  assign len     = mlpf_pkg::reply_len(exp_q);
  assign cnt_inc = cnt_q + 4'd1;
  assign got     = {sh_q[0], head_i.rx_byte};

  // sequencer and reply checker
  always_comb begin
    crc_d   = crc_q;
    exp_d   = exp_q;
    cnt_d   = cnt_q;
    await_d = await_q;
    idx_d   = idx_q;
    sh_d    = sh_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    res_d   = '0;

    if (valid_i && !head_i.is_reply) begin
      // send one frame byte
      if (out_free) begin
        load           = 1'b1;
        res_d.tx_valid = 1'b1;
        res_d.tx_byte  = tx_b;
        res_d.tx_last  = (idx_q == head_i.last_idx);
        if (!crc_sel) begin
          crc_d = mlpf_pkg::crc_byte(crc_base, tx_b);
        end
        if (idx_q == 4'd0) begin
          exp_d   = head_i.reply_kind;
          cnt_d   = 4'd0;
          await_d = 1'b1;
        end
        if (idx_q == head_i.last_idx) begin
          pop_o = 1'b1;
          idx_d = 4'd0;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end
    end else if (valid_i && head_i.is_reply) begin
      if (!await_q) begin
        // stray reply byte
        pop_o = 1'b1;
      end else if (out_free) begin
        pop_o = 1'b1;
        if ({1'b0, len} > MaxBytes) begin
          load              = 1'b1;
          res_d.reply_valid = 1'b1;
          res_d.status      = mlpf_pkg::ST_LEN;
          await_d           = 1'b0;
        end else begin
          sh_d[0] = head_i.rx_byte;
          for (int i = 1; i < mlpf_pkg::ShiftBytes; i++) begin
            sh_d[i] = sh_q[i-1];
          end
          if (exp_q != mlpf_pkg::RK_ACK && cnt_q < (len - 4'd2)) begin
            crc_d = mlpf_pkg::crc_byte(crc_q, head_i.rx_byte);
          end
          cnt_d = cnt_inc;
          if (cnt_inc != len) begin
            // short reply
            if (head_i.rx_last) begin
              load              = 1'b1;
              res_d.reply_valid = 1'b1;
              res_d.status      = mlpf_pkg::ST_LEN;
              await_d           = 1'b0;
            end
          end else begin
            load              = 1'b1;
            res_d.reply_valid = 1'b1;
            await_d           = 1'b0;
            if (exp_q == mlpf_pkg::RK_ACK) begin
              res_d.status = (head_i.rx_byte == mlpf_pkg::AckByte) ?
                             mlpf_pkg::ST_OK : mlpf_pkg::ST_ACK;
            end else if (got != crc_q) begin
              res_d.status = mlpf_pkg::ST_CRC;
            end else begin
              res_d.status = mlpf_pkg::ST_OK;
              unique case (exp_q)
                mlpf_pkg::RK_W16: begin
                  res_d.word_a = {16'h0000, sh_q[2], sh_q[1]};
                end
                mlpf_pkg::RK_W32S: begin
                  res_d.word_a      = {sh_q[5], sh_q[4], sh_q[3], sh_q[2]};
                  res_d.status_byte = sh_q[1];
                end
                mlpf_pkg::RK_W64: begin
                  res_d.word_a = {sh_q[8], sh_q[7], sh_q[6], sh_q[5]};
                  res_d.word_b = {sh_q[4], sh_q[3], sh_q[2], sh_q[1]};
                end
                default: begin
                  res_d.word_a = '0;
                end
              endcase
            end
          end
        end
      end
    end
  end

  // output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= 16'h0000;
      exp_q       <= mlpf_pkg::RK_ACK;
      cnt_q       <= 4'd0;
      await_q     <= 1'b0;
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      exp_q       <= exp_d;
      cnt_q       <= cnt_d;
      await_q     <= await_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // reply byte history and result payload
  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    if (load) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ----- tb/tb_motor_link_packet_framer_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_motor_link_packet_framer_top: stream testbench for the packet framer
// Drives command frames and reply bytes into the block with random gaps on
// both sides, predicts every frame byte and reply report in a scoreboard
// and compares each output item field by field against the oldest one due.
// ----------------------------------------------------------------------------
module tb_motor_link_packet_framer_top;

  localparam int unsigned MaxReply   = 10;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned LongHold   = 400;
  localparam logic [1:0]  PlUnused   = 2'd3;

  // flaws applied to a reply sequence
  localparam int FlawNone    = 0;
  localparam int FlawBadCrc  = 1;
  localparam int FlawShort   = 2;
  localparam int FlawDropped = 3;

  // one input item as the host sees it
  typedef struct packed {
    logic        action;
    logic [7:0]  address;
    logic [7:0]  command;
    logic [1:0]  payload_kind;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic [1:0]  reply_kind;
    logic [7:0]  rx_byte;
    logic        rx_last;
  } link_item_t;

  // expected frame bytes and reply reports, with a copy of the link state
  class frame_scoreboard;
    logic [15:0]     crc;
    logic [1:0]      exp_kind;
    int              count;
    logic [7:0]      store [MaxReply];
    bit              awaiting;
    mlpf_pkg::res_t  due_q [$];
    int unsigned     fails;
    int unsigned     checked;

    function new();
      crc      = '0;
      exp_kind = '0;
      count    = 0;
      awaiting = 1'b0;
      fails    = 0;
      checked  = 0;
    endfunction

    static function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
        r = r[15] ? ({r[14:0], 1'b0} ^ mlpf_pkg::CrcPoly) : {r[14:0], 1'b0};
      end
      return r;
    endfunction

    static function int reply_bytes(logic [1:0] k);
      case (k)
        mlpf_pkg::RK_ACK:  return 1;
        mlpf_pkg::RK_W16:  return 4;
        mlpf_pkg::RK_W32S: return 7;
        default:           return 10;
      endcase
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void push_tx(logic [7:0] b, bit last, bit into_crc);
      mlpf_pkg::res_t r;
      r = '0;
      r.tx_valid = 1'b1;
      r.tx_byte  = b;
      r.tx_last  = last;
      if (into_crc) crc = crc16_step(crc, b);
      due_q.push_back(r);
    endfunction

    // work out the output items caused by one accepted input item
    function void note(link_item_t it);
      mlpf_pkg::res_t    r;
      mlpf_pkg::status_e st;
      int                len;
      logic [31:0]       wa;
      logic [31:0]       wb;
      logic [7:0]        sbyte;
      logic [15:0]       got;
      if (!it.action) begin
        crc      = '0;
        exp_kind = it.reply_kind;
        count    = 0;
        awaiting = 1'b1;
        push_tx(it.address, 1'b0, 1'b1);
        if (it.payload_kind == mlpf_pkg::PL_W16) begin
          push_tx(it.command, 1'b0, 1'b1);
          push_tx(it.value_a[15:8], 1'b0, 1'b1);
          push_tx(it.value_a[7:0], 1'b0, 1'b1);
          push_tx(it.value_b[15:8], 1'b0, 1'b1);
          push_tx(it.value_b[7:0], 1'b0, 1'b1);
        end else if (it.payload_kind == mlpf_pkg::PL_W32) begin
          push_tx(it.command, 1'b0, 1'b1);
          for (int s = 3; s >= 0; s--) push_tx(it.value_a[s*8 +: 8], 1'b0, 1'b1);
          for (int s = 3; s >= 0; s--) push_tx(it.value_b[s*8 +: 8], 1'b0, 1'b1);
        end else begin
          // read frame, or the unused payload code: no crc sent
          push_tx(it.command, 1'b1, 1'b1);
          return;
        end
        push_tx(crc[15:8], 1'b0, 1'b0);
        push_tx(crc[7:0], 1'b1, 1'b0);
        return;
      end
      // reply byte with nothing awaited is dropped
      if (!awaiting) return;
      len   = reply_bytes(exp_kind);
      st    = mlpf_pkg::ST_OK;
      wa    = '0;
      wb    = '0;
      sbyte = '0;
      if (len > MaxReply) begin
        st = mlpf_pkg::ST_LEN;
      end else begin
        if (count < len) begin
          store[count] = it.rx_byte;
          if (exp_kind != mlpf_pkg::RK_ACK && count < len - 2)
            crc = crc16_step(crc, it.rx_byte);
          count++;
        end
        if (count < len) begin
          if (!it.rx_last) return;
          st = mlpf_pkg::ST_LEN;
        end else if (exp_kind == mlpf_pkg::RK_ACK) begin
          st = (store[0] == mlpf_pkg::AckByte) ? mlpf_pkg::ST_OK : mlpf_pkg::ST_ACK;
        end else begin
          got = {store[len-2], store[len-1]};
          if (got != crc) begin
            st = mlpf_pkg::ST_CRC;
          end else if (exp_kind == mlpf_pkg::RK_W16) begin
            wa = {16'h0000, store[0], store[1]};
          end else if (exp_kind == mlpf_pkg::RK_W32S) begin
            wa    = {store[0], store[1], store[2], store[3]};
            sbyte = store[4];
          end else begin
            wa = {store[0], store[1], store[2], store[3]};
            wb = {store[4], store[5], store[6], store[7]};
          end
        end
      end
      awaiting      = 1'b0;
      r             = '0;
      r.reply_valid = 1'b1;
      r.status      = st;
      r.word_a      = wa;
      r.word_b      = wb;
      r.status_byte = sbyte;
      due_q.push_back(r);
    endfunction

    // compare one output item with the oldest one due
    function void check(mlpf_pkg::res_t got);
      mlpf_pkg::res_t want;
      checked++;
      if (due_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected output item %h", got);
        return;
      end
      want = due_q.pop_front();
      if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
          got.tx_last !== want.tx_last || got.reply_valid !== want.reply_valid ||
          got.status !== want.status || got.word_a !== want.word_a ||
          got.word_b !== want.word_b || got.status_byte !== want.status_byte) begin
        fails++;
        if (fails <= 10) begin
          $display("mismatch on output item %0d: expected tx %b %h %b rep %b %0d %h %h %h",
                   checked, want.tx_valid, want.tx_byte, want.tx_last, want.reply_valid,
                   want.status, want.word_a, want.word_b, want.status_byte);
          $display("                              got tx %b %h %b rep %b %0d %h %h %h",
                   got.tx_valid, got.tx_byte, got.tx_last, got.reply_valid,
                   got.status, got.word_a, got.word_b, got.status_byte);
        end
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [mlpf_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                          s_axis_tuser = 1'b0;
  logic                          s_axis_tlast = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [mlpf_pkg::OutDataW-1:0] m_axis_tdata;
  logic [1:0]                    m_axis_tuser;
  logic                          m_axis_tlast;

  frame_scoreboard link_sb = new();

  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned items_driven = 0;
  int unsigned ignored_items = 0;
  int unsigned frames_sent = 0;
  int unsigned reply_bytes_sent = 0;

  motor_link_packet_framer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock and cycle count
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // watchdog
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles", cycle_count);
    $display("simulation failed");
    $finish;
  end

  // receiver side: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = LongHold;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    mlpf_pkg::res_t r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      r.tx_valid    = m_axis_tuser[0];
      r.tx_byte     = m_axis_tdata[7:0];
      r.tx_last     = m_axis_tlast;
      r.reply_valid = m_axis_tuser[1];
      r.status      = mlpf_pkg::status_e'(m_axis_tdata[9:8]);
      r.word_a      = m_axis_tdata[41:10];
      r.word_b      = m_axis_tdata[73:42];
      r.status_byte = m_axis_tdata[81:74];
      link_sb.check(r);
    end
  end

  function automatic link_item_t frame_item(logic [7:0] addr, logic [7:0] cmd,
                                            logic [1:0] pk, logic [31:0] va,
                                            logic [31:0] vb, logic [1:0] rk);
    link_item_t it;
    it.action       = 1'b0;
    it.address      = addr;
    it.command      = cmd;
    it.payload_kind = pk;
    it.value_a      = va;
    it.value_b      = vb;
    it.reply_kind   = rk;
    it.rx_byte      = 8'($urandom);
    it.rx_last      = 1'($urandom);
    return it;
  endfunction

  function automatic link_item_t rx_item(logic [7:0] b, logic last);
    link_item_t it;
    it.action       = 1'b1;
    it.address      = 8'($urandom);
    it.command      = 8'($urandom);
    it.payload_kind = 2'($urandom);
    it.value_a      = $urandom;
    it.value_b      = $urandom;
    it.reply_kind   = 2'($urandom);
    it.rx_byte      = b;
    it.rx_last      = last;
    return it;
  endfunction

  function automatic link_item_t random_frame();
    logic [1:0] pk;
    pk = ($urandom_range(9) == 0) ? PlUnused : 2'($urandom_range(2));
    return frame_item(8'($urandom), 8'($urandom), pk, $urandom, $urandom,
                      2'($urandom_range(3)));
  endfunction

  // offer one item after a random gap, hold until taken
  task automatic drive_item(link_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, it.rx_byte, it.reply_kind, it.value_b, it.value_a,
                      it.payload_kind, it.command, it.address};
    s_axis_tuser  <= it.action;
    s_axis_tlast  <= it.rx_last;
    do @(posedge clk_i); while (!s_axis_tready);
    link_sb.note(it);
    items_driven++;
    if (it.action) reply_bytes_sent++;
    else frames_sent++;
  endtask

  // pause the sender until every due output item has arrived
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (link_sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // reply bytes for the frame just sent, built on the running crc
  task automatic reply_sequence(int flaw);
    logic [7:0]  bytes [$];
    logic [15:0] c;
    logic [7:0]  b;
    int          len;
    int          cut;
    int          pos;
    logic        last;
    len = frame_scoreboard::reply_bytes(link_sb.exp_kind);
    c   = link_sb.crc;
    if (link_sb.exp_kind == mlpf_pkg::RK_ACK) begin
      bytes.push_back(($urandom_range(3) != 0) ? mlpf_pkg::AckByte : 8'($urandom));
    end else begin
      for (int i = 0; i < len - 2; i++) begin
        b = 8'($urandom);
        c = frame_scoreboard::crc16_step(c, b);
        bytes.push_back(b);
      end
      bytes.push_back(c[15:8]);
      bytes.push_back(c[7:0]);
      if (flaw == FlawBadCrc) begin
        pos = $urandom_range(len - 1);
        bytes[pos] = bytes[pos] ^ (8'h01 << $urandom_range(7));
      end
    end
    cut = len;
    if (flaw == FlawShort && len > 1) cut = $urandom_range(len - 1, 1);
    if (flaw == FlawDropped) cut = $urandom_range(len - 1);
    for (int i = 0; i < cut; i++) begin
      if (i != cut - 1) last = 1'b0;
      else if (flaw == FlawShort) last = 1'b1;
      else if (flaw == FlawDropped) last = 1'b0;
      else last = 1'($urandom);
      drive_item(rx_item(bytes[i], last));
    end
  endtask

  // random traffic: mostly clean exchanges, some broken ones and noise
  task automatic run_traffic(int unsigned target);
    int unsigned r;
    while (items_driven - ignored_items < target) begin
      r = $urandom_range(99);
      if (r < 6) begin
        if (!link_sb.awaiting) begin
          ignored_items++;
          drive_item(rx_item(8'($urandom), 1'($urandom)));
        end
      end else begin
        drive_item(random_frame());
        r = $urandom_range(99);
        if (r < 72) reply_sequence(FlawNone);
        else if (r < 84) reply_sequence(FlawBadCrc);
        else if (r < 93) reply_sequence(FlawShort);
        else reply_sequence(FlawDropped);
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_pct = 26;
    rx_idle_pct = 68;

    // directed: extremes, every payload layout and reply kind, the odd cases
    drive_item(frame_item(8'h00, 8'h00, mlpf_pkg::PL_READ, '0, '0, mlpf_pkg::RK_ACK));
    drive_item(rx_item(mlpf_pkg::AckByte, 1'b1));
    drive_item(frame_item(8'hFF, 8'hFF, mlpf_pkg::PL_W16, 32'hFFFF_FFFF, 32'h0,
                          mlpf_pkg::RK_W16));
    reply_sequence(FlawNone);
    drive_item(frame_item(8'h80, 8'h7F, mlpf_pkg::PL_W32, 32'h7FFF_FFFF, 32'h8000_0000,
                          mlpf_pkg::RK_W32S));
    reply_sequence(FlawNone);
    // ack byte not all ones
    drive_item(frame_item(8'h01, 8'h15, mlpf_pkg::PL_READ, '0, '0, mlpf_pkg::RK_ACK));
    drive_item(rx_item(8'h00, 1'b0));
    // stray reply byte with no reply awaited
    drive_item(rx_item(8'hAB, 1'b1));
    ignored_items++;
    // crc mismatch
    drive_item(frame_item(8'h55, 8'hAA, mlpf_pkg::PL_W16, 32'h1234_5678, 32'hFFFF_0000,
                          mlpf_pkg::RK_W16));
    reply_sequence(FlawBadCrc);
    // reply cut short
    drive_item(frame_item(8'h80, 8'h1F, mlpf_pkg::PL_READ, '0, '0, mlpf_pkg::RK_W16));
    reply_sequence(FlawShort);
    // unused payload code, then a new frame while a reply is still pending
    drive_item(frame_item(8'h7F, 8'h80, PlUnused, 32'h8000_0000, 32'h7FFF_FFFF,
                          mlpf_pkg::RK_W64));
    drive_item(rx_item(8'hFF, 1'b0));
    drive_item(frame_item(8'h81, 8'h01, mlpf_pkg::PL_READ, '0, '0, mlpf_pkg::RK_ACK));
    drive_item(rx_item(mlpf_pkg::AckByte, 1'b0));
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    run_traffic(items_driven - ignored_items + 50);
    wait_drained();

    tx_idle_pct = 68;
    rx_idle_pct = 26;
    run_traffic(items_driven - ignored_items + 50);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_traffic(items_driven - ignored_items + 50);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (link_sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (link_sb.pending() != 0) begin
      link_sb.fails += link_sb.pending();
      $display("%0d output items never arrived", link_sb.pending());
    end

    $display("sent %0d command frames and %0d reply bytes (%0d stray)",
             frames_sent, reply_bytes_sent, ignored_items);
    $display("compared %0d output items, %0d failures", link_sb.checked, link_sb.fails);
    if (link_sb.fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/mlpf_pkg.sv
design/mlpf_front.sv
design/mlpf_queue.sv
design/mlpf_back.sv
design/motor_link_packet_framer_top.sv
tb/tb_motor_link_packet_framer_top.sv
